FILE: design/sap_pkg.sv
// sap_pkg: opcodes and field widths shared by the small accumulator cpu core
package sap_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned NibW  = 4;

  // item kinds carried on the input tuser bit
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // instruction opcodes, high nibble of the instruction byte
  typedef enum logic [3:0] {
    OP_NOP  = 4'h0,
    OP_LDA  = 4'h1,
    OP_ADD  = 4'h2,
    OP_SUB  = 4'h3,
    OP_STA  = 4'h4,
    OP_LDI  = 4'h5,
    OP_JMP  = 4'h6,
    OP_JC   = 4'h7,
    OP_JZ   = 4'h8,
    OP_ADDI = 4'h9,
    OP_SUBI = 4'hA,
    OP_LDB  = 4'hB,
    OP_JNC  = 4'hC,
    OP_JNZ  = 4'hD,
    OP_OUT  = 4'hE,
    OP_HLT  = 4'hF
  } op_t;

endpackage

FILE: design/sap_8bit_cpu_core_unit.sv
// sap_8bit_cpu_core_unit: 8-bit accumulator cpu with a 16-byte program store
//
// Input stream: each transaction is either a write of one byte into the
// program store (tuser = 0, address and data in tdata) or a step that runs
// one whole instruction (tuser = 1). Every input transaction yields exactly
// one output transaction carrying a snapshot of pc, ir, a, b, the out
// register, the out strobe and the carry, zero and halt flags.
// out_tvalid rises in the cycle after input acceptance. Throughput is one
// transaction per cycle while in_tready is high: the whole instruction
// (fetch at pc, operand read, alu, store) is resolved in one combinational
// pass over the register-file store and committed at the accepting edge.
// The output register holds one result; a new input is taken while that
// result is being taken in the same cycle, so a stalled receiver stalls the
// input only once the output register is full.
// Reset clears all cpu registers, the flags and all 16 store bytes at once;
// the block is ready as soon as reset is released.
// After a halt instruction, steps change nothing; writes still land.
module sap_8bit_cpu_core_unit
  import sap_pkg::*;
#(
  parameter int unsigned RAM_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] address, [11:4] data, [15:12] zero
  input  logic [15:0] in_tdata,
  // [0] command
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] program_counter, [11:4] instruction, [19:12] accumulator,
  // [27:20] operand_register, [35:28] output_register, [36] output_written,
  // [37] carry, [38] zero, [39] halted
  output logic [39:0] out_tdata
);

  localparam int unsigned AW = $clog2(RAM_WORDS);

  // program store and cpu state
  logic [DataW-1:0] mem_r [RAM_WORDS];
  logic [AW-1:0]    pc_r, pc_nxt;
  logic [DataW-1:0] ir_r, ir_nxt;
  logic [DataW-1:0] acc_r, acc_nxt;
  logic [DataW-1:0] breg_r, breg_nxt;
  logic [DataW-1:0] outreg_r, outreg_nxt;
  logic             carry_r, carry_nxt;
  logic             zero_r, zero_nxt;
  logic             halt_r, halt_nxt;
  logic             wrote_nxt;

  // store write port
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DataW-1:0] wdata;

  // output register
  logic             out_valid_r;
  logic [39:0]      out_data_r, out_data_nxt;

  logic             accept;
  cmd_t             cmd;
  logic [NibW-1:0]  in_addr;
  logic [DataW-1:0] in_data;
  logic [DataW-1:0] fetch;
  op_t              op;
  logic [NibW-1:0]  arg;
  logic [DataW-1:0] opnd;
  logic [DataW-1:0] alu_b;
  logic [DataW:0]   sum;
  logic [DataW-1:0] diff;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign in_addr   = in_tdata[3:0];
  assign in_data   = in_tdata[11:4];

  // fetch at pc, then operand read at the low nibble
  assign fetch = mem_r[pc_r];
  assign op    = op_t'(fetch[7:4]);
  assign arg   = fetch[3:0];
  assign opnd  = mem_r[arg[AW-1:0]];

  // alu operand is the store byte or the immediate nibble
  always_comb begin
    if (op == OP_ADDI || op == OP_SUBI) begin
      alu_b = {{(DataW-NibW){1'b0}}, arg};
    end else begin
      alu_b = opnd;
    end
  end

  assign sum  = {1'b0, acc_r} + {1'b0, alu_b};
  assign diff = acc_r - alu_b;

  // next state for one transaction
  always_comb begin
    pc_nxt     = pc_r;
    ir_nxt     = ir_r;
    acc_nxt    = acc_r;
    breg_nxt   = breg_r;
    outreg_nxt = outreg_r;
    carry_nxt  = carry_r;
    zero_nxt   = zero_r;
    halt_nxt   = halt_r;
    wrote_nxt  = 1'b0;
    we         = 1'b0;
    waddr      = in_addr[AW-1:0];
    wdata      = in_data;
    if (cmd == CMD_WRITE) begin
      we = 1'b1;
    end else if (!halt_r) begin
      ir_nxt = fetch;
      pc_nxt = pc_r + AW'(1);
      case (op)
        OP_NOP: begin
        end
        OP_LDA: acc_nxt = opnd;
        OP_ADD, OP_ADDI: begin
          breg_nxt  = alu_b;
          acc_nxt   = sum[DataW-1:0];
          carry_nxt = sum[DataW];
          zero_nxt  = (sum[DataW-1:0] == '0);
        end
        OP_SUB, OP_SUBI: begin
          breg_nxt  = alu_b;
          acc_nxt   = diff[DataW-1:0];
          carry_nxt = (acc_r < alu_b);
          zero_nxt  = (diff[DataW-1:0] == '0);
        end
        OP_STA: begin
          we    = 1'b1;
          waddr = arg[AW-1:0];
          wdata = acc_r;
        end
        OP_LDI: acc_nxt = {{(DataW-NibW){1'b0}}, arg};
        OP_JMP: pc_nxt = arg[AW-1:0];
        OP_JC:  if (carry_r) pc_nxt = arg[AW-1:0];
        OP_JZ:  if (zero_r) pc_nxt = arg[AW-1:0];
        OP_LDB: breg_nxt = opnd;
        OP_JNC: if (!carry_r) pc_nxt = arg[AW-1:0];
        OP_JNZ: if (!zero_r) pc_nxt = arg[AW-1:0];
        OP_OUT: begin
          outreg_nxt = acc_r;
          wrote_nxt  = 1'b1;
        end
        OP_HLT: halt_nxt = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // result snapshot packing
  assign out_data_nxt = {halt_nxt, zero_nxt, carry_nxt, wrote_nxt, outreg_nxt,
                         breg_nxt, acc_nxt, ir_nxt, NibW'(pc_nxt)};

  // cpu state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      ir_r     <= '0;
      acc_r    <= '0;
      breg_r   <= '0;
      outreg_r <= '0;
      carry_r  <= 1'b0;
      zero_r   <= 1'b0;
      halt_r   <= 1'b0;
    end else if (accept) begin
      pc_r     <= pc_nxt;
      ir_r     <= ir_nxt;
      acc_r    <= acc_nxt;
      breg_r   <= breg_nxt;
      outreg_r <= outreg_nxt;
      carry_r  <= carry_nxt;
      zero_r   <= zero_nxt;
      halt_r   <= halt_nxt;
    end
  end

  // program store, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RAM_WORDS; i++) begin
        mem_r[i] <= '0;
      end
    end else if (accept && we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // once halted, only reset clears the halt flag
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped");

  // a step while halted leaves the program counter alone
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && halt_r && in_tuser) |=> $stable(pc_r))
    else $error("pc moved while halted");

  // a write transaction never reports an out strobe
  a_write_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tuser) |=> (out_tvalid && !out_tdata[36]))
    else $error("write transaction flagged output_written");

  // every accepted transaction is presented on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("result missing after accepted transaction");
`endif

endmodule
